/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the block.
// Stands alone; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked assertion that is switched off while reset is high.
`define SPI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// An implication that is checked in the same cycle.
`define SPI_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
  `SPI_ASSERT(lbl, clk, rst, (pre) |-> (post), msg)

`endif

/* rtl/spi_pkg.sv */
// Shared constants and types of the segment-plane intersection block.
// Used by every module file of the block; depends on nothing.
package spi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int T_BITS = 16;
  localparam int T_W = T_BITS + 1;
  localparam int COORD_W = 32;
  localparam int NORM_W = 18;
  localparam int OFFS_W = 32;
  localparam int EPS_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W = COORD_W + NORM_W;
  localparam int BITS_PER_STAGE = 2;

  typedef enum logic [2:0] {
    OUT_BOTH_ON  = 3'd0,
    OUT_FIRST_ON = 3'd1,
    OUT_SECOND_ON = 3'd2,
    OUT_SAME_SIDE = 3'd3,
    OUT_DEGENERATE = 3'd4,
    OUT_CROSSING = 3'd5
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_EPSILON = 3'd4
  } reg_index_t;

  typedef struct packed {
    outcome_t outcome;
    logic crossing;
    logic do_div;
  } item_info_t;

endpackage

/* rtl/spi_div.sv */
// Pipelined restoring divider that produces the Q1.16 crossing parameter.
// Depends on spi_pkg; two quotient bits are resolved per register stage.
module spi_div #(
  parameter int RW = 54
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [RW-1:0] in_rem,
  input  logic [RW-1:0] in_div,
  input  logic [spi_pkg::T_W-1:0] in_quot,
  input  spi_pkg::item_info_t in_info,
  output logic out_valid,
  output logic [spi_pkg::T_W-1:0] out_quot,
  output spi_pkg::item_info_t out_info
);

  localparam int NS = spi_pkg::T_BITS / spi_pkg::BITS_PER_STAGE;

  logic valid [NS+1];
  logic [RW-1:0] rem [NS+1];
  logic [RW-1:0] dvs [NS+1];
  logic [spi_pkg::T_W-1:0] quot [NS+1];
  spi_pkg::item_info_t info [NS+1];

  assign valid[0] = in_valid;
  assign rem[0] = in_rem;
  assign dvs[0] = in_div;
  assign quot[0] = in_quot;
  assign info[0] = in_info;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [RW-1:0] rem_next;
    logic [spi_pkg::T_W-1:0] quot_next;

    always_comb begin
      logic [RW:0] shifted;
      rem_next = rem[i];
      quot_next = quot[i];
      for (int k = 0; k < spi_pkg::BITS_PER_STAGE; k++) begin
        shifted = {rem_next, 1'b0};
        if (info[i].do_div) begin
          if (shifted >= {1'b0, dvs[i]}) begin
            shifted = shifted - {1'b0, dvs[i]};
            quot_next = {quot_next[spi_pkg::T_W-2:0], 1'b1};
          end else begin
            quot_next = {quot_next[spi_pkg::T_W-2:0], 1'b0};
          end
          rem_next = shifted[RW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= valid[i];
      end
      if (en) begin
        rem[i+1] <= rem_next;
        dvs[i+1] <= dvs[i];
        quot[i+1] <= quot_next;
        info[i+1] <= info[i];
      end
    end
  end

  assign out_valid = valid[NS];
  assign out_quot = quot[NS];
  assign out_info = info[NS];

endmodule

/* rtl/segment_plane_intersection.sv */
// Top level of the segment-plane intersection block: config registers,
// distance pipeline and classification. Depends on spi_pkg and spi_div.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------
//   input    | in_valid/in_ready  | ax ay az bx by bz
//   output   | out_valid/out_ready| crossing t_fraction outcome
//   config   | cfg_we             | cfg_index cfg_data
//
// One request enters per cycle unless the output stalls; each result
// passes 3 distance and classification stages, then 8 divider stages of two bits.
// Reset clears the valid bits and loads the register reset values.
// The whole pipeline holds while the output register is full and unread.
module segment_plane_intersection #(
  parameter int FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [spi_pkg::COORD_W-1:0] ax,
  input  logic signed [spi_pkg::COORD_W-1:0] ay,
  input  logic signed [spi_pkg::COORD_W-1:0] az,
  input  logic signed [spi_pkg::COORD_W-1:0] bx,
  input  logic signed [spi_pkg::COORD_W-1:0] by,
  input  logic signed [spi_pkg::COORD_W-1:0] bz,
  output logic out_valid,
  input  logic out_ready,
  output logic crossing,
  output logic [spi_pkg::T_W-1:0] t_fraction,
  output logic [2:0] outcome,
  input  logic cfg_we,
  input  logic [spi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spi_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int OT_W = spi_pkg::OFFS_W + FRAC_BITS;
  localparam int DIST_W = ((OT_W > spi_pkg::PROD_W + 2) ? OT_W : spi_pkg::PROD_W + 2) + 1;
  localparam int RW = DIST_W + 1;
  localparam int PW = spi_pkg::PROD_W;

  logic signed [spi_pkg::NORM_W-1:0] normal_x;
  logic signed [spi_pkg::NORM_W-1:0] normal_y;
  logic signed [spi_pkg::NORM_W-1:0] normal_z;
  logic signed [spi_pkg::OFFS_W-1:0] plane_offset;
  logic [spi_pkg::EPS_W-1:0] epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= spi_pkg::NORM_W'(65536);
      plane_offset <= '0;
      epsilon <= spi_pkg::EPS_W'(7);
    end else if (cfg_we) begin
      case (cfg_index)
        spi_pkg::REG_NORMAL_X: normal_x <= cfg_data[spi_pkg::NORM_W-1:0];
        spi_pkg::REG_NORMAL_Y: normal_y <= cfg_data[spi_pkg::NORM_W-1:0];
        spi_pkg::REG_NORMAL_Z: normal_z <= cfg_data[spi_pkg::NORM_W-1:0];
        spi_pkg::REG_PLANE_OFFSET: plane_offset <= cfg_data[spi_pkg::OFFS_W-1:0];
        spi_pkg::REG_EPSILON: epsilon <= cfg_data[spi_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: six products.
  logic v1;
  logic signed [PW-1:0] pax, pay, paz, pbx, pby, pbz;

  // Stage 2: signed distances.
  logic v2;
  logic signed [DIST_W-1:0] da, db;
  logic signed [DIST_W-1:0] offs_term;
  assign offs_term = DIST_W'(plane_offset) <<< FRAC_BITS;

  // Stage 3: classification.
  logic v3;
  logic [RW-1:0] rem3, sum3;
  logic [spi_pkg::T_W-1:0] quot3;
  spi_pkg::item_info_t info3;

  logic [DIST_W-1:0] aa, ab;
  logic [RW-1:0] sum_ab, eps_q;
  logic a_on, b_on;
  spi_pkg::item_info_t info_next;
  logic [spi_pkg::T_W-1:0] quot_next;

  always_comb begin
    aa = da[DIST_W-1] ? DIST_W'(-da) : DIST_W'(da);
    ab = db[DIST_W-1] ? DIST_W'(-db) : DIST_W'(db);
    sum_ab = RW'(aa) + RW'(ab);
    eps_q = RW'(epsilon) << FRAC_BITS;
    a_on = RW'(aa) <= eps_q;
    b_on = RW'(ab) <= eps_q;
    info_next = '{outcome: spi_pkg::OUT_SAME_SIDE, crossing: 1'b0, do_div: 1'b0};
    quot_next = '0;
    if (a_on && b_on) begin
      info_next.outcome = spi_pkg::OUT_BOTH_ON;
    end else if (a_on) begin
      info_next.outcome = spi_pkg::OUT_FIRST_ON;
      info_next.crossing = 1'b1;
    end else if (b_on) begin
      info_next.outcome = spi_pkg::OUT_SECOND_ON;
      info_next.crossing = 1'b1;
      quot_next = spi_pkg::T_W'(1) << spi_pkg::T_BITS;
    end else if ((da > 0) == (db > 0)) begin
      info_next.outcome = spi_pkg::OUT_SAME_SIDE;
    end else if (sum_ab < eps_q) begin
      info_next.outcome = spi_pkg::OUT_DEGENERATE;
    end else begin
      info_next.outcome = spi_pkg::OUT_CROSSING;
      info_next.crossing = 1'b1;
      info_next.do_div = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      pax <= PW'(ax) * PW'(normal_x);
      pay <= PW'(ay) * PW'(normal_y);
      paz <= PW'(az) * PW'(normal_z);
      pbx <= PW'(bx) * PW'(normal_x);
      pby <= PW'(by) * PW'(normal_y);
      pbz <= PW'(bz) * PW'(normal_z);
      da <= DIST_W'(pax) + DIST_W'(pay) + DIST_W'(paz) - offs_term;
      db <= DIST_W'(pbx) + DIST_W'(pby) + DIST_W'(pbz) - offs_term;
      rem3 <= RW'(aa);
      sum3 <= sum_ab;
      quot3 <= quot_next;
      info3 <= info_next;
    end
  end

  spi_pkg::item_info_t info_out;

  spi_div #(
    .RW(RW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(v3),
    .in_rem(rem3),
    .in_div(sum3),
    .in_quot(quot3),
    .in_info(info3),
    .out_valid(out_valid),
    .out_quot(t_fraction),
    .out_info(info_out)
  );

  assign crossing = info_out.crossing;
  assign outcome = info_out.outcome;

endmodule

/* rtl/spi_chk.sv */
// Port-level checker for the segment-plane intersection block.
// Depends on spi_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module spi_chk (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic crossing,
  input logic [spi_pkg::T_W-1:0] t_fraction,
  input logic [2:0] outcome
);

  logic stall;
  logic hit_code;
  logic is_second;
  logic is_cross;
  logic [spi_pkg::T_W-1:0] t_one;
  logic [spi_pkg::T_W+3:0] res;

  assign stall = out_valid && !out_ready;
  assign is_second = outcome == spi_pkg::OUT_SECOND_ON;
  assign is_cross = outcome == spi_pkg::OUT_CROSSING;
  assign hit_code = (outcome == spi_pkg::OUT_FIRST_ON) || is_second || is_cross;
  assign t_one = spi_pkg::T_W'(1) << spi_pkg::T_BITS;
  assign res = {crossing, t_fraction, outcome};

  `SPI_ASSERT(a_out_hold, clk, rst, stall |=> out_valid && $stable(res), "stalled result changed")
  `SPI_ASSERT_IMP(a_cross_code, clk, rst, out_valid, crossing == hit_code, "crossing flag is wrong")
  `SPI_ASSERT_IMP(a_second_t, clk, rst, out_valid && is_second, t_fraction == t_one, "t is not one")
  `SPI_ASSERT_IMP(a_miss_t, clk, rst, out_valid && !crossing, t_fraction == '0, "miss has nonzero t")
  `SPI_ASSERT_IMP(a_cross_t, clk, rst, out_valid && is_cross, !t_fraction[spi_pkg::T_BITS], "t reaches one")

endmodule

bind segment_plane_intersection spi_chk u_spi_chk (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .crossing(crossing),
  .t_fraction(t_fraction),
  .outcome(outcome)
);
